@@ hw/rtl/aoptrk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoptrk_pkg: shared types and helpers for the operation phase tracker
// Command, phase and outcome codes, and the legal phase transition check.
// ----------------------------------------------------------------------------
package aoptrk_pkg;

   localparam int unsigned CMD_W     = 3;
   localparam int unsigned ID_W      = 32;
   localparam int unsigned PHASE_W   = 4;
   localparam int unsigned OUTCOME_W = 4;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned GEN_W     = 32;
   localparam int unsigned VER_W     = 32;
   localparam int unsigned FLAGS_W   = 2;

   localparam logic [VER_W-1:0] VERSION_MAX = {VER_W{1'b1}};

   typedef enum logic [CMD_W-1:0] {
      CMD_QUEUE   = 3'd0,
      CMD_BEGIN   = 3'd1,
      CMD_PUBLISH = 3'd2,
      CMD_CANCEL  = 3'd3,
      CMD_FINISH  = 3'd4,
      CMD_RESET   = 3'd5
   } cmd_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE        = 4'd0,
      PH_QUEUED      = 4'd1,
      PH_DISCOVERING = 4'd2,
      PH_WAIT_SEL    = 4'd3,
      PH_SECURE      = 4'd4,
      PH_RAM         = 4'd5,
      PH_PERSIST     = 4'd6,
      PH_MQTT        = 4'd7,
      PH_COMPLETED   = 4'd8,
      PH_CANCELLED   = 4'd9,
      PH_FAILED      = 4'd10
   } phase_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OC_NONE        = 4'd0,
      OC_SUCCESS     = 4'd1,
      OC_BUSY        = 4'd2,
      OC_SELREQ      = 4'd3,
      OC_CANCELLED   = 4'd4,
      OC_INVALID     = 4'd5,
      OC_DISC_FAIL   = 4'd6,
      OC_PAIR_FAIL   = 4'd7,
      OC_PERSIST_FAIL = 4'd8,
      OC_MQTT_FAIL   = 4'd9
   } outcome_type;

   // Terminal phases: a new operation may be queued from these.
   function automatic logic is_terminal(input phase_type ph);
      return (ph == PH_COMPLETED) || (ph == PH_CANCELLED) ||
             (ph == PH_FAILED) || (ph == PH_WAIT_SEL);
   endfunction

   // Staying in the same phase is always legal.
   function automatic logic is_legal(input phase_type from_ph,
                                     input logic [PHASE_W-1:0] to_ph);
      logic [(1<<PHASE_W)-1:0] mask;
      unique case (from_ph)
         PH_IDLE:        mask = 16'(1) << PH_QUEUED;
         PH_QUEUED:      mask = (16'(1) << PH_DISCOVERING) | (16'(1) << PH_SECURE) |
                                (16'(1) << PH_CANCELLED) | (16'(1) << PH_FAILED);
         PH_DISCOVERING: mask = (16'(1) << PH_WAIT_SEL) | (16'(1) << PH_SECURE) |
                                (16'(1) << PH_CANCELLED) | (16'(1) << PH_FAILED);
         PH_WAIT_SEL:    mask = 16'(1) << PH_QUEUED;
         PH_SECURE:      mask = (16'(1) << PH_RAM) | (16'(1) << PH_CANCELLED) |
                                (16'(1) << PH_FAILED);
         PH_RAM:         mask = (16'(1) << PH_PERSIST) | (16'(1) << PH_COMPLETED) |
                                (16'(1) << PH_CANCELLED) | (16'(1) << PH_FAILED);
         PH_PERSIST:     mask = (16'(1) << PH_MQTT) | (16'(1) << PH_CANCELLED) |
                                (16'(1) << PH_FAILED);
         PH_MQTT:        mask = (16'(1) << PH_COMPLETED) | (16'(1) << PH_CANCELLED) |
                                (16'(1) << PH_FAILED);
         PH_COMPLETED:   mask = 16'(1) << PH_QUEUED;
         PH_CANCELLED:   mask = 16'(1) << PH_QUEUED;
         PH_FAILED:      mask = 16'(1) << PH_QUEUED;
         default:        mask = '0;
      endcase
      return (from_ph == to_ph) || mask[to_ph];
   endfunction

endpackage

@@ hw/rtl/async_operation_phase_tracker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// async_operation_phase_tracker_core: operation phase tracker
// Checks queue/begin/publish/cancel/finish/reset commands against the phase
// transition table and returns an accepted flag with the full status snapshot.
// ----------------------------------------------------------------------------
//
//  channel  | direction | words                       | handshake
//  ---------+-----------+-----------------------------+-----------------
//  req_*    | in        | one command word            | req_valid/ready
//  rsp_*    | out       | one status word per command | rsp_valid/ready
//
// The transition check and the state update sit between the state registers
// and themselves, and the state registers double as the result payload. One
// command word is accepted per cycle while req_ready is high.
// req_ready is high while the result slot is empty or being taken this cycle,
// so a stalled rsp side holds the state and stalls req by exactly that slot.
// Reset (synchronous, active high) clears all state and drops rsp_valid.
//
module async_operation_phase_tracker_core (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [aoptrk_pkg::CMD_W-1:0]      req_cmd,
   input  logic [aoptrk_pkg::ID_W-1:0]       req_op_id,
   input  logic [aoptrk_pkg::PHASE_W-1:0]    req_target_phase,
   input  logic [aoptrk_pkg::OUTCOME_W-1:0]  req_result_code,
   input  logic [aoptrk_pkg::BYTE_W-1:0]     req_client_status,
   input  logic [aoptrk_pkg::BYTE_W-1:0]     req_client_fault,
   input  logic [aoptrk_pkg::BYTE_W-1:0]     req_candidates_seen,
   input  logic [aoptrk_pkg::GEN_W-1:0]      req_cred_generation,
   input  logic                              req_needs_selection,
   input  logic                              req_creds_staged,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_accepted,
   output logic [aoptrk_pkg::ID_W-1:0]       rsp_cur_op_id,
   output logic [aoptrk_pkg::PHASE_W-1:0]    rsp_phase,
   output logic [aoptrk_pkg::OUTCOME_W-1:0]  rsp_outcome,
   output logic                              rsp_is_active,
   output logic                              rsp_cancel_pending,
   output logic [aoptrk_pkg::VER_W-1:0]      rsp_version,
   output logic [aoptrk_pkg::BYTE_W-1:0]     rsp_snap_client_status,
   output logic [aoptrk_pkg::BYTE_W-1:0]     rsp_snap_client_fault,
   output logic [aoptrk_pkg::BYTE_W-1:0]     rsp_snap_candidates,
   output logic [aoptrk_pkg::GEN_W-1:0]      rsp_snap_cred_generation,
   output logic [aoptrk_pkg::FLAGS_W-1:0]    rsp_snap_client_flags
);

   // Tracker state; these registers are also the result payload.
   logic                              rsp_valid_ff;
   logic                              accepted_ff,      accepted_in;
   logic [aoptrk_pkg::ID_W-1:0]       op_id_ff,         op_id_in;
   aoptrk_pkg::phase_type             phase_ff,         phase_in;
   aoptrk_pkg::outcome_type           outcome_ff,       outcome_in;
   logic                              active_ff,        active_in;
   logic                              cancel_ff,        cancel_in;
   logic [aoptrk_pkg::VER_W-1:0]      version_ff,       version_in;
   logic [aoptrk_pkg::BYTE_W-1:0]     client_status_ff, client_status_in;
   logic [aoptrk_pkg::BYTE_W-1:0]     client_fault_ff,  client_fault_in;
   logic [aoptrk_pkg::BYTE_W-1:0]     candidates_ff,    candidates_in;
   logic [aoptrk_pkg::GEN_W-1:0]      cred_gen_ff,      cred_gen_in;
   logic [aoptrk_pkg::FLAGS_W-1:0]    client_flags_ff,  client_flags_in;

   logic                              req_fire;
   logic                              latch_snap;
   logic [aoptrk_pkg::VER_W-1:0]      version_bumped;
   aoptrk_pkg::phase_type             finish_phase;
   logic                              finish_code_ok;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign version_bumped = (version_ff == aoptrk_pkg::VERSION_MAX) ?
                           version_ff : version_ff + aoptrk_pkg::VER_W'(1);

   // Map the finish outcome to its terminal phase.
   always_comb begin
      finish_code_ok = 1'b1;
      finish_phase   = aoptrk_pkg::PH_FAILED;
      priority if (req_result_code == aoptrk_pkg::OC_SUCCESS) begin
         finish_phase = aoptrk_pkg::PH_COMPLETED;
      end else if (req_result_code == aoptrk_pkg::OC_CANCELLED) begin
         finish_phase = aoptrk_pkg::PH_CANCELLED;
      end else if (req_result_code == aoptrk_pkg::OC_SELREQ) begin
         finish_phase = aoptrk_pkg::PH_WAIT_SEL;
      end else if (req_result_code == aoptrk_pkg::OC_NONE ||
                   req_result_code == aoptrk_pkg::OC_BUSY ||
                   req_result_code > aoptrk_pkg::OC_MQTT_FAIL) begin
         finish_code_ok = 1'b0;
      end else begin
         finish_phase = aoptrk_pkg::PH_FAILED;
      end
   end

   // Command decode: start from the held state, apply the accepted command.
   always_comb begin
      accepted_in = 1'b0;
      latch_snap  = 1'b0;
      op_id_in    = op_id_ff;
      phase_in    = phase_ff;
      outcome_in  = outcome_ff;
      active_in   = active_ff;
      cancel_in   = cancel_ff;
      version_in  = version_ff;

      unique case (aoptrk_pkg::cmd_type'(req_cmd))
         aoptrk_pkg::CMD_QUEUE: begin
            if (req_op_id != '0 && !active_ff &&
                (aoptrk_pkg::is_terminal(phase_ff) || phase_ff == aoptrk_pkg::PH_IDLE) &&
                req_op_id > op_id_ff) begin
               accepted_in = 1'b1;
               latch_snap  = 1'b1;
               op_id_in    = req_op_id;
               phase_in    = aoptrk_pkg::PH_QUEUED;
               outcome_in  = aoptrk_pkg::OC_NONE;
               active_in   = 1'b1;
               cancel_in   = 1'b0;
               version_in  = version_bumped;
            end
         end
         aoptrk_pkg::CMD_BEGIN: begin
            // Queued to discovering is always in the table.
            if (active_ff && phase_ff == aoptrk_pkg::PH_QUEUED) begin
               accepted_in = 1'b1;
               latch_snap  = 1'b1;
               phase_in    = aoptrk_pkg::PH_DISCOVERING;
               version_in  = version_bumped;
            end
         end
         aoptrk_pkg::CMD_PUBLISH: begin
            // Targets past failed have no table bit and are rejected.
            if (active_ff && aoptrk_pkg::is_legal(phase_ff, req_target_phase)) begin
               accepted_in = 1'b1;
               latch_snap  = 1'b1;
               phase_in    = aoptrk_pkg::phase_type'(req_target_phase);
               version_in  = version_bumped;
            end
         end
         aoptrk_pkg::CMD_CANCEL: begin
            // Sticky flag; bump only on the first request.
            if (active_ff && !aoptrk_pkg::is_terminal(phase_ff)) begin
               accepted_in = 1'b1;
               cancel_in   = 1'b1;
               if (!cancel_ff) begin
                  version_in = version_bumped;
               end
            end
         end
         aoptrk_pkg::CMD_FINISH: begin
            if (active_ff && finish_code_ok &&
                aoptrk_pkg::is_legal(phase_ff, finish_phase)) begin
               accepted_in = 1'b1;
               latch_snap  = 1'b1;
               phase_in    = finish_phase;
               outcome_in  = aoptrk_pkg::outcome_type'(req_result_code);
               active_in   = 1'b0;
               version_in  = version_bumped;
            end
         end
         aoptrk_pkg::CMD_RESET: begin
            // Clear phase, outcome and flags, keep the id; version still advances.
            accepted_in = 1'b1;
            latch_snap  = 1'b1;
            phase_in    = aoptrk_pkg::PH_IDLE;
            outcome_in  = aoptrk_pkg::OC_NONE;
            active_in   = 1'b0;
            cancel_in   = 1'b0;
            version_in  = version_bumped;
         end
         default: begin
            accepted_in = 1'b0;
         end
      endcase
   end

   // Snapshot latch: take the client data on every accepted non-cancel word.
   always_comb begin
      client_status_in = client_status_ff;
      client_fault_in  = client_fault_ff;
      candidates_in    = candidates_ff;
      cred_gen_in      = cred_gen_ff;
      client_flags_in  = client_flags_ff;
      if (latch_snap) begin
         client_status_in = req_client_status;
         client_fault_in  = req_client_fault;
         candidates_in    = req_candidates_seen;
         cred_gen_in      = req_cred_generation;
         client_flags_in  = {req_creds_staged, req_needs_selection};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         accepted_ff      <= 1'b0;
         op_id_ff         <= '0;
         phase_ff         <= aoptrk_pkg::PH_IDLE;
         outcome_ff       <= aoptrk_pkg::OC_NONE;
         active_ff        <= 1'b0;
         cancel_ff        <= 1'b0;
         version_ff       <= '0;
         client_status_ff <= '0;
         client_fault_ff  <= '0;
         candidates_ff    <= '0;
         cred_gen_ff      <= '0;
         client_flags_ff  <= '0;
      end else begin
         if (req_fire) begin
            rsp_valid_ff     <= 1'b1;
            accepted_ff      <= accepted_in;
            op_id_ff         <= op_id_in;
            phase_ff         <= phase_in;
            outcome_ff       <= outcome_in;
            active_ff        <= active_in;
            cancel_ff        <= cancel_in;
            version_ff       <= version_in;
            client_status_ff <= client_status_in;
            client_fault_ff  <= client_fault_in;
            candidates_ff    <= candidates_in;
            cred_gen_ff      <= cred_gen_in;
            client_flags_ff  <= client_flags_in;
         end else if (rsp_ready) begin
            // Drop the result word once taken.
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_accepted             = accepted_ff;
   assign rsp_cur_op_id            = op_id_ff;
   assign rsp_phase                = phase_ff;
   assign rsp_outcome              = outcome_ff;
   assign rsp_is_active            = active_ff;
   assign rsp_cancel_pending       = cancel_ff;
   assign rsp_version              = version_ff;
   assign rsp_snap_client_status   = client_status_ff;
   assign rsp_snap_client_fault    = client_fault_ff;
   assign rsp_snap_candidates      = candidates_ff;
   assign rsp_snap_cred_generation = cred_gen_ff;
   assign rsp_snap_client_flags    = client_flags_ff;

   // Version never goes backward, reset command included.
   assert property (@(posedge clock) disable iff (reset)
      !reset |=> version_ff >= $past(version_ff))
      else $error("version counter went backward");

   // Operation ids never go backward.
   assert property (@(posedge clock) disable iff (reset)
      !reset |=> op_id_ff >= $past(op_id_ff))
      else $error("operation id went backward");

   // An active operation is never idle.
   assert property (@(posedge clock) disable iff (reset)
      active_ff |-> phase_ff != aoptrk_pkg::PH_IDLE)
      else $error("active flag set in idle phase");

   // Cancel leaves the client snapshot alone.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_cmd == aoptrk_pkg::CMD_CANCEL |=>
         $stable(client_status_ff) && $stable(cred_gen_ff) && $stable(client_flags_ff))
      else $error("cancel changed the client snapshot");

endmodule

@@ sim/async_operation_phase_tracker_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// async_operation_phase_tracker_core_test: phase tracker command/status check
// Drives command words through the req channel and checks every status word
// against an in-bench model of the phase table, the id rule and the counters.
// A short scripted opening hits rejections and edge values, then mostly legal
// operation sessions with random client data follow, with some noise mixed in.
// ----------------------------------------------------------------------------
module async_operation_phase_tracker_core_test;
   import aoptrk_pkg::*;

   // Codes outside the defined sets, used to provoke rejections.
   localparam logic [CMD_W-1:0]     CMD_UNDEF_A = 3'd6;
   localparam logic [CMD_W-1:0]     CMD_UNDEF_B = 3'd7;
   localparam logic [PHASE_W-1:0]   PH_BEYOND   = 4'd15;
   localparam logic [OUTCOME_W-1:0] RC_BEYOND   = 4'd15;

   localparam int RANDOM_WORDS = 1000;
   localparam int ID_STEP_MAX  = 8_000_000;
   localparam int CYCLE_LIMIT  = 100_000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_AT      = 600;   // receiver cycle that starts the long hold-off
   localparam int HOLD_LEN     = 400;
   localparam int CALM_FROM    = 100;   // window with no idling on either side
   localparam int CALM_TO      = 500;

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [ID_W-1:0]      op_id;
      logic [PHASE_W-1:0]   target_phase;
      logic [OUTCOME_W-1:0] result_code;
      logic [BYTE_W-1:0]    client_status;
      logic [BYTE_W-1:0]    client_fault;
      logic [BYTE_W-1:0]    candidates_seen;
      logic [GEN_W-1:0]     cred_generation;
      logic                 needs_selection;
      logic                 creds_staged;
   } cmd_word_t;

   typedef struct packed {
      logic                 accepted;
      logic [ID_W-1:0]      cur_op_id;
      logic [PHASE_W-1:0]   phase;
      logic [OUTCOME_W-1:0] outcome;
      logic                 is_active;
      logic                 cancel_pending;
      logic [VER_W-1:0]     version;
      logic [BYTE_W-1:0]    snap_client_status;
      logic [BYTE_W-1:0]    snap_client_fault;
      logic [BYTE_W-1:0]    snap_candidates;
      logic [GEN_W-1:0]     snap_cred_generation;
      logic [FLAGS_W-1:0]   snap_client_flags;
   } status_t;

   // One scripted command. fill sets all client data to ones (else zeros).
   // Where typed is set, the listed status fields are spelled out by hand.
   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [ID_W-1:0]      op_id;
      logic [PHASE_W-1:0]   tgt;
      logic [OUTCOME_W-1:0] rc;
      logic                 fill;
      logic                 typed;
      logic                 acc;
      logic [PHASE_W-1:0]   ph;
      logic [OUTCOME_W-1:0] oc;
      logic                 act;
      logic                 cxl;
      logic [VER_W-1:0]     ver;
   } script_row_t;

   localparam script_row_t OPENING_ROWS [25] = '{
      // nothing is active yet: publish, cancel, finish, a zero-id queue and undefined codes bounce
      '{CMD_PUBLISH, 32'd0, PH_QUEUED, OC_NONE, '0, '1, '0, PH_IDLE, OC_NONE, '0, '0, 32'd0},
      '{CMD_QUEUE, 32'd0, PH_IDLE, OC_NONE, '1, '1, '0, PH_IDLE, OC_NONE, '0, '0, 32'd0},
      '{CMD_CANCEL, 32'd0, PH_IDLE, OC_NONE, '0, '1, '0, PH_IDLE, OC_NONE, '0, '0, 32'd0},
      '{CMD_FINISH, 32'd0, PH_IDLE, OC_SUCCESS, '0, '1, '0, PH_IDLE, OC_NONE, '0, '0, 32'd0},
      '{CMD_UNDEF_A, 32'd9, PH_IDLE, OC_NONE, '1, '1, '0, PH_IDLE, OC_NONE, '0, '0, 32'd0},
      '{CMD_UNDEF_B, 32'd9, PH_IDLE, OC_NONE, '1, '1, '0, PH_IDLE, OC_NONE, '0, '0, 32'd0},
      // open an operation with all-ones client data, then walk it
      '{CMD_QUEUE, 32'd1, PH_IDLE, OC_NONE, '1, '1, '1, PH_QUEUED, OC_NONE, '1, '0, 32'd1},
      '{CMD_QUEUE, 32'd2, PH_IDLE, OC_NONE, '0, '1, '0, PH_QUEUED, OC_NONE, '1, '0, 32'd1},
      '{CMD_BEGIN, 32'd0, PH_IDLE, OC_NONE, '0, '1, '1, PH_DISCOVERING, OC_NONE, '1, '0, 32'd2},
      '{CMD_BEGIN, 32'd0, PH_IDLE, OC_NONE, '1, '1, '0, PH_DISCOVERING, OC_NONE, '1, '0, 32'd2},
      '{CMD_PUBLISH, 32'd0, PH_BEYOND, OC_NONE, '1, '1, '0, PH_DISCOVERING, OC_NONE, '1, '0, 32'd2},
      '{CMD_PUBLISH, 32'd0, PH_DISCOVERING, OC_NONE, '1, '1, '1, PH_DISCOVERING, OC_NONE, '1, '0,
        32'd3},
      // cancel is sticky and bumps the version only once
      '{CMD_CANCEL, 32'd0, PH_IDLE, OC_NONE, '0, '1, '1, PH_DISCOVERING, OC_NONE, '1, '1, 32'd4},
      '{CMD_CANCEL, 32'd0, PH_IDLE, OC_NONE, '0, '1, '1, PH_DISCOVERING, OC_NONE, '1, '1, 32'd4},
      '{CMD_PUBLISH, 32'd0, PH_SECURE, OC_NONE, '1, '1, '1, PH_SECURE, OC_NONE, '1, '1, 32'd5},
      // finish with codes that never map, one that maps to an illegal hop, one good
      '{CMD_FINISH, 32'd0, PH_IDLE, OC_NONE, '0, '1, '0, PH_SECURE, OC_NONE, '1, '1, 32'd5},
      '{CMD_FINISH, 32'd0, PH_IDLE, OC_BUSY, '0, '1, '0, PH_SECURE, OC_NONE, '1, '1, 32'd5},
      '{CMD_FINISH, 32'd0, PH_IDLE, RC_BEYOND, '0, '1, '0, PH_SECURE, OC_NONE, '1, '1, 32'd5},
      '{CMD_FINISH, 32'd0, PH_IDLE, OC_SELREQ, '0, '1, '0, PH_SECURE, OC_NONE, '1, '1, 32'd5},
      '{CMD_FINISH, 32'd0, PH_IDLE, OC_MQTT_FAIL, '1, '1, '1, PH_FAILED, OC_MQTT_FAIL, '0, '1,
        32'd6},
      // inactive again: cancel, publish and a stale id bounce, reset keeps the id
      '{CMD_CANCEL, 32'd0, PH_IDLE, OC_NONE, '0, '1, '0, PH_FAILED, OC_MQTT_FAIL, '0, '1, 32'd6},
      '{CMD_QUEUE, 32'd1, PH_IDLE, OC_NONE, '0, '1, '0, PH_FAILED, OC_MQTT_FAIL, '0, '1, 32'd6},
      '{CMD_PUBLISH, 32'd0, PH_QUEUED, OC_NONE, '0, '1, '0, PH_FAILED, OC_MQTT_FAIL, '0, '1, 32'd6},
      '{CMD_RESET, 32'd0, PH_IDLE, OC_NONE, '0, '1, '1, PH_IDLE, OC_NONE, '0, '0, 32'd7},
      '{CMD_QUEUE, 32'd3, PH_IDLE, OC_NONE, '0, '0, '0, PH_IDLE, OC_NONE, '0, '0, 32'd0}
   };

   // Top id last: once taken, no later queue can ever pass.
   localparam script_row_t CLOSING_ROWS [6] = '{
      '{CMD_RESET, 32'd0, PH_IDLE, OC_NONE, '1, '0, '0, PH_IDLE, OC_NONE, '0, '0, 32'd0},
      '{CMD_QUEUE, 32'hFFFF_FFFF, PH_IDLE, OC_NONE, '1, '0, '0, PH_IDLE, OC_NONE, '0, '0, 32'd0},
      '{CMD_FINISH, 32'd0, PH_IDLE, OC_SUCCESS, '0, '0, '0, PH_IDLE, OC_NONE, '0, '0, 32'd0},
      '{CMD_FINISH, 32'd0, PH_IDLE, OC_CANCELLED, '1, '0, '0, PH_IDLE, OC_NONE, '0, '0, 32'd0},
      '{CMD_QUEUE, 32'hFFFF_FFFF, PH_IDLE, OC_NONE, '0, '0, '0, PH_IDLE, OC_NONE, '0, '0, 32'd0},
      '{CMD_RESET, 32'd0, PH_IDLE, OC_NONE, '0, '0, '0, PH_IDLE, OC_NONE, '0, '0, 32'd0}
   };

   // Legal next phases, one bit per destination; staying put is handled apart.
   localparam logic [15:0] NEXT_OK [16] = '{
      (16'd1 << PH_QUEUED),
      (16'd1 << PH_DISCOVERING) | (16'd1 << PH_SECURE) | (16'd1 << PH_CANCELLED) |
         (16'd1 << PH_FAILED),
      (16'd1 << PH_WAIT_SEL) | (16'd1 << PH_SECURE) | (16'd1 << PH_CANCELLED) |
         (16'd1 << PH_FAILED),
      (16'd1 << PH_QUEUED),
      (16'd1 << PH_RAM) | (16'd1 << PH_CANCELLED) | (16'd1 << PH_FAILED),
      (16'd1 << PH_PERSIST) | (16'd1 << PH_COMPLETED) | (16'd1 << PH_CANCELLED) |
         (16'd1 << PH_FAILED),
      (16'd1 << PH_MQTT) | (16'd1 << PH_CANCELLED) | (16'd1 << PH_FAILED),
      (16'd1 << PH_COMPLETED) | (16'd1 << PH_CANCELLED) | (16'd1 << PH_FAILED),
      (16'd1 << PH_QUEUED),
      (16'd1 << PH_QUEUED),
      (16'd1 << PH_QUEUED),
      16'd0, 16'd0, 16'd0, 16'd0, 16'd0
   };

   localparam logic [OUTCOME_W-1:0] FINISH_CODES [8] = '{
      OC_SUCCESS, OC_SELREQ, OC_CANCELLED, OC_INVALID,
      OC_DISC_FAIL, OC_PAIR_FAIL, OC_PERSIST_FAIL, OC_MQTT_FAIL
   };

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [CMD_W-1:0]      req_cmd;
   logic [ID_W-1:0]       req_op_id;
   logic [PHASE_W-1:0]    req_target_phase;
   logic [OUTCOME_W-1:0]  req_result_code;
   logic [BYTE_W-1:0]     req_client_status;
   logic [BYTE_W-1:0]     req_client_fault;
   logic [BYTE_W-1:0]     req_candidates_seen;
   logic [GEN_W-1:0]      req_cred_generation;
   logic                  req_needs_selection;
   logic                  req_creds_staged;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_accepted;
   logic [ID_W-1:0]       rsp_cur_op_id;
   logic [PHASE_W-1:0]    rsp_phase;
   logic [OUTCOME_W-1:0]  rsp_outcome;
   logic                  rsp_is_active;
   logic                  rsp_cancel_pending;
   logic [VER_W-1:0]      rsp_version;
   logic [BYTE_W-1:0]     rsp_snap_client_status;
   logic [BYTE_W-1:0]     rsp_snap_client_fault;
   logic [BYTE_W-1:0]     rsp_snap_candidates;
   logic [GEN_W-1:0]      rsp_snap_cred_generation;
   logic [FLAGS_W-1:0]    rsp_snap_client_flags;

   status_t tracker_state;          // model copy of the tracker registers
   status_t pending_status_q[$];    // status words still owed by the block
   int      fail_count  = 0;
   int      cycle_count = 0;

   async_operation_phase_tracker_core DUT (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_cmd                  (req_cmd),
      .req_op_id                (req_op_id),
      .req_target_phase         (req_target_phase),
      .req_result_code          (req_result_code),
      .req_client_status        (req_client_status),
      .req_client_fault         (req_client_fault),
      .req_candidates_seen      (req_candidates_seen),
      .req_cred_generation      (req_cred_generation),
      .req_needs_selection      (req_needs_selection),
      .req_creds_staged         (req_creds_staged),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_accepted             (rsp_accepted),
      .rsp_cur_op_id            (rsp_cur_op_id),
      .rsp_phase                (rsp_phase),
      .rsp_outcome              (rsp_outcome),
      .rsp_is_active            (rsp_is_active),
      .rsp_cancel_pending       (rsp_cancel_pending),
      .rsp_version              (rsp_version),
      .rsp_snap_client_status   (rsp_snap_client_status),
      .rsp_snap_client_fault    (rsp_snap_client_fault),
      .rsp_snap_candidates      (rsp_snap_candidates),
      .rsp_snap_cred_generation (rsp_snap_cred_generation),
      .rsp_snap_client_flags    (rsp_snap_client_flags)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Tracker model
   // ---------------------------------------------------------------------

   function automatic logic phase_settled(input logic [PHASE_W-1:0] p);
      return p == PH_COMPLETED || p == PH_CANCELLED || p == PH_FAILED || p == PH_WAIT_SEL;
   endfunction

   function automatic logic phase_step_ok(input logic [PHASE_W-1:0] from_ph,
                                          input logic [PHASE_W-1:0] to_ph);
      return (from_ph == to_ph) || NEXT_OK[from_ph][to_ph];
   endfunction

   function automatic void bump_version();
      if (tracker_state.version != VERSION_MAX)
         tracker_state.version = tracker_state.version + 1'b1;
   endfunction

   function automatic void take_snapshot(input cmd_word_t w);
      tracker_state.snap_client_status   = w.client_status;
      tracker_state.snap_client_fault    = w.client_fault;
      tracker_state.snap_candidates      = w.candidates_seen;
      tracker_state.snap_cred_generation = w.cred_generation;
      tracker_state.snap_client_flags    = {w.creds_staged, w.needs_selection};
   endfunction

   // Shared by begin and publish: move only when active and the hop is legal.
   function automatic logic advance_phase(input logic [PHASE_W-1:0] tgt, input cmd_word_t w);
      if (!tracker_state.is_active || !phase_step_ok(tracker_state.phase, tgt))
         return 1'b0;
      tracker_state.phase = tgt;
      take_snapshot(w);
      bump_version();
      return 1'b1;
   endfunction

   // Apply one command word to the model and return the status it should produce.
   function automatic status_t next_status(input cmd_word_t w);
      logic                 ok;
      logic [PHASE_W-1:0]   dest;
      logic [ID_W-1:0]      keep_id;
      logic [VER_W-1:0]     keep_ver;
      ok = 1'b0;
      case (w.cmd)
         CMD_QUEUE: begin
            if (w.op_id != '0 && !tracker_state.is_active &&
                (phase_settled(tracker_state.phase) || tracker_state.phase == PH_IDLE) &&
                w.op_id > tracker_state.cur_op_id) begin
               tracker_state.cur_op_id      = w.op_id;
               tracker_state.phase          = PH_QUEUED;
               tracker_state.outcome        = OC_NONE;
               tracker_state.is_active      = 1'b1;
               tracker_state.cancel_pending = 1'b0;
               take_snapshot(w);
               bump_version();
               ok = 1'b1;
            end
         end
         CMD_BEGIN: begin
            if (tracker_state.is_active && tracker_state.phase == PH_QUEUED)
               ok = advance_phase(PH_DISCOVERING, w);
         end
         CMD_PUBLISH: ok = advance_phase(w.target_phase, w);
         CMD_CANCEL: begin
            // accepted while a live phase runs; the version moves on the first request only
            if (tracker_state.is_active && !phase_settled(tracker_state.phase)) begin
               if (!tracker_state.cancel_pending) begin
                  tracker_state.cancel_pending = 1'b1;
                  bump_version();
               end
               ok = 1'b1;
            end
         end
         CMD_FINISH: begin
            if (tracker_state.is_active && w.result_code != OC_NONE &&
                w.result_code != OC_BUSY && w.result_code <= OC_MQTT_FAIL) begin
               case (w.result_code)
                  OC_SUCCESS:   dest = PH_COMPLETED;
                  OC_CANCELLED: dest = PH_CANCELLED;
                  OC_SELREQ:    dest = PH_WAIT_SEL;
                  default:      dest = PH_FAILED;
               endcase
               if (phase_step_ok(tracker_state.phase, dest)) begin
                  tracker_state.phase     = dest;
                  tracker_state.outcome   = w.result_code;
                  tracker_state.is_active = 1'b0;
                  take_snapshot(w);
                  bump_version();
                  ok = 1'b1;
               end
            end
         end
         CMD_RESET: begin
            // wipe all but the id and version; the version still counts this change
            keep_id  = tracker_state.cur_op_id;
            keep_ver = tracker_state.version;
            tracker_state           = '0;
            tracker_state.cur_op_id = keep_id;
            tracker_state.version   = keep_ver;
            bump_version();
            take_snapshot(w);
            ok = 1'b1;
         end
         default: ;
      endcase
      tracker_state.accepted = ok;
      return tracker_state;
   endfunction

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------

   function automatic logic calm_now();
      return cycle_count >= CALM_FROM && cycle_count < CALM_TO;
   endfunction

   // Offer one command word, sometimes after an idle gap, and hold it until the block takes it.
   task automatic offer_word(input cmd_word_t w, input status_t want);
      int gap;
      gap = 0;
      if (!calm_now() && $urandom_range(0, 99) < 9)
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : 1;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pending_status_q.push_back(want);
      req_valid           <= 1'b1;
      req_cmd             <= w.cmd;
      req_op_id           <= w.op_id;
      req_target_phase    <= w.target_phase;
      req_result_code     <= w.result_code;
      req_client_status   <= w.client_status;
      req_client_fault    <= w.client_fault;
      req_candidates_seen <= w.candidates_seen;
      req_cred_generation <= w.cred_generation;
      req_needs_selection <= w.needs_selection;
      req_creds_staged    <= w.creds_staged;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic run_script_row(input script_row_t row);
      cmd_word_t w;
      status_t   want;
      w                 = '0;
      w.cmd             = row.cmd;
      w.op_id           = row.op_id;
      w.target_phase    = row.tgt;
      w.result_code     = row.rc;
      w.client_status   = {BYTE_W{row.fill}};
      w.client_fault    = {BYTE_W{row.fill}};
      w.candidates_seen = {BYTE_W{row.fill}};
      w.cred_generation = {GEN_W{row.fill}};
      w.needs_selection = row.fill;
      w.creds_staged    = row.fill;
      want = next_status(w);
      if (row.typed) begin
         want.accepted       = row.acc;
         want.phase          = row.ph;
         want.outcome        = row.oc;
         want.is_active      = row.act;
         want.cancel_pending = row.cxl;
         want.version        = row.ver;
      end
      offer_word(w, want);
   endtask

   initial begin : stimulus
      cmd_word_t          w;
      status_t            want;
      int                 roll;
      logic [PHASE_W-1:0] t;
      tracker_state       = '0;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_cmd             = '0;
      req_op_id           = '0;
      req_target_phase    = '0;
      req_result_code     = '0;
      req_client_status   = '0;
      req_client_fault    = '0;
      req_candidates_seen = '0;
      req_cred_generation = '0;
      req_needs_selection = 1'b0;
      req_creds_staged    = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (OPENING_ROWS[i]) run_script_row(OPENING_ROWS[i]);

      // Mostly well-formed sessions: queue, begin, walk legal hops, finish.
      // A slice of the words is resets, noise, stale ids, or hops the table refuses.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         w.op_id           = $urandom;
         w.target_phase    = 4'($urandom_range(0, 15));
         w.result_code     = 4'($urandom_range(0, 15));
         w.client_status   = 8'($urandom);
         w.client_fault    = 8'($urandom);
         w.candidates_seen = 8'($urandom);
         w.cred_generation = $urandom;
         w.needs_selection = 1'($urandom);
         w.creds_staged    = 1'($urandom);
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            w.cmd = 3'($urandom_range(0, 7));
            // keep noise from grabbing a huge id and starving later sessions
            if (w.cmd == CMD_QUEUE)
               w.op_id = $urandom_range(0, tracker_state.cur_op_id);
         end else if (roll < 12) begin
            w.cmd = CMD_RESET;
         end else if (!tracker_state.is_active) begin
            w.cmd = CMD_QUEUE;
            if (roll < 20)
               w.op_id = $urandom_range(0, tracker_state.cur_op_id);
            else
               w.op_id = tracker_state.cur_op_id + $urandom_range(1, ID_STEP_MAX);
         end else if (roll < 22) begin
            w.cmd = CMD_CANCEL;
         end else if (roll < 40) begin
            w.cmd = CMD_FINISH;
            if (roll < 37)
               w.result_code = FINISH_CODES[$urandom_range(0, 7)];
         end else if (tracker_state.phase == PH_QUEUED && roll < 70) begin
            w.cmd = CMD_BEGIN;
         end else begin
            w.cmd = CMD_PUBLISH;
            if (roll < 95) begin
               // look for a legal hop away from the current phase
               t = tracker_state.phase;
               for (int k = 0; k < 8 && t == tracker_state.phase; k++) begin
                  t = 4'($urandom_range(0, 10));
                  if (!phase_step_ok(tracker_state.phase, t))
                     t = tracker_state.phase;
               end
               w.target_phase = t;
            end
         end
         want = next_status(w);
         offer_word(w, want);
      end

      foreach (CLOSING_ROWS[i]) run_script_row(CLOSING_ROWS[i]);
      req_valid <= 1'b0;

      // Drain: wait for every owed status word, then idle a while before the verdict.
      while (pending_status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("PASS async_operation_phase_tracker_core");
      else
         $display("FAIL async_operation_phase_tracker_core");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: random stalls, one long hold-off to back the block up,
   // and a calm window with rsp_ready held high.
   // ---------------------------------------------------------------------
   initial begin : receiver
      int hold_left;
      int seen;
      hold_left = 0;
      seen      = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         seen++;
         if (seen == HOLD_AT)
            hold_left = HOLD_LEN;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (calm_now()) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 11);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Checker
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : status_check
      status_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_status_q.size() == 0) begin
            $error("status word arrived with none outstanding");
            fail_count++;
         end else begin
            want = pending_status_q.pop_front();
            check_field("accepted", want.accepted, rsp_accepted);
            check_field("cur_op_id", want.cur_op_id, rsp_cur_op_id);
            check_field("phase", want.phase, rsp_phase);
            check_field("outcome", want.outcome, rsp_outcome);
            check_field("is_active", want.is_active, rsp_is_active);
            check_field("cancel_pending", want.cancel_pending, rsp_cancel_pending);
            check_field("version", want.version, rsp_version);
            check_field("snap_client_status", want.snap_client_status, rsp_snap_client_status);
            check_field("snap_client_fault", want.snap_client_fault, rsp_snap_client_fault);
            check_field("snap_candidates", want.snap_candidates, rsp_snap_candidates);
            check_field("snap_cred_generation", want.snap_cred_generation,
                        rsp_snap_cred_generation);
            check_field("snap_client_flags", want.snap_client_flags, rsp_snap_client_flags);
         end
      end
   end

   // Watchdog: drop the run if it overstays the cycle budget.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL async_operation_phase_tracker_core");
         $finish;
      end
   end

endmodule

@@ filelist.f @@
hw/rtl/aoptrk_pkg.sv
hw/rtl/async_operation_phase_tracker_core.sv
sim/async_operation_phase_tracker_core_test.sv
